@@ design/hsl_to_rgb_converter_defines.svh @@
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// Checks sample on clk and sleep while rst_n is low.
`define HSL2RGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HSL2RGB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/hsl2rgb_pkg.sv @@
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    localparam int H_W   = 9;
    localparam int C_W   = 8;
    localparam int V_W   = 16;
    localparam int L2_W  = 17;
    localparam int F_W   = 6;
    localparam int N_W   = 22;
    localparam int CH_N  = 3;
    localparam int Q_W   = 9;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int HUE_WRAP      = 360;
    localparam int HUE_THIRD     = 120;
    localparam int HUE_TWO_THIRD = 240;
    localparam int RAMP_SPAN     = 60;
    localparam int RAMP_HOLD_END = 180;
    localparam int RAMP_FALL_END = 240;

    localparam int FULL       = 255;
    localparam int TWO_FULL   = 2 * FULL;
    localparam int VV_FULL    = FULL * FULL;
    localparam int LIGHT_HALF = 127;

    localparam int N_MAX      = VV_FULL * RAMP_SPAN;
    localparam int OUT_DIV    = FULL * RAMP_SPAN;
    localparam int ROUND_BIAS = OUT_DIV / 2;
    localparam int X_MAX      = N_MAX + ROUND_BIAS;

    // floor(x / OUT_DIV) as (x * K) >> SHIFT; exact for x < 2**N_W
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 23;
    localparam int P_W         = N_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(OUT_DIV) - 64'd1) / 64'(OUT_DIV);
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_FULL[RECIP_W-1:0];

    typedef struct packed {
        logic [H_W-1:0] hue_deg;
        logic [C_W-1:0] saturation;
        logic [C_W-1:0] lightness;
    } pixel_hsl_t;

    typedef struct packed {
        logic [C_W-1:0] red;
        logic [C_W-1:0] green;
        logic [C_W-1:0] blue;
    } pixel_rgb_t;

    typedef struct packed {
        logic [H_W-1:0] hue;
        logic           lower_half;
        logic [C_W-1:0] lightness;
        logic [V_W-1:0] prod;
    } front_a_t;

    typedef struct packed {
        logic [V_W-1:0]             v1;
        logic [V_W-1:0]             span;
        logic [CH_N-1:0][F_W-1:0]   frac;
    } ramp_op_t;

    typedef struct packed {
        logic [N_W-1:0]             base;
        logic [CH_N-1:0][N_W-1:0]   rise;
    } ramp_mid_t;

    typedef struct packed {
        logic [CH_N-1:0][N_W-1:0]   num;
    } scale_op_t;

    // weight of (v2 - v1) at channel angle t, in sixtieths
    function automatic logic [F_W-1:0] ramp_frac(input logic [H_W-1:0] t);
        logic [F_W-1:0] f;
        if (t < H_W'(RAMP_SPAN))
            f = t[F_W-1:0];
        else if (t < H_W'(RAMP_HOLD_END))
            f = F_W'(RAMP_SPAN);
        else if (t < H_W'(RAMP_FALL_END))
            f = F_W'(H_W'(RAMP_FALL_END) - t);
        else
            f = '0;
        return f;
    endfunction

endpackage

@@ design/hsl_to_rgb_converter.sv @@
// HSL to RGB pixel converter. Takes one pixel per clock while pixel_stall is
// low and moves it through stages: hue reduce and v2 product, v1/v2 and ramp
// weights, per-channel ramp multiply, rounding add, reciprocal divide into the
// output register. Every stage has its own valid bit and moves when the stage
// after it is empty or draining, so empty slots close up under rgb_stall and
// pixel_stall rises only when all five stages hold a pixel.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"

module hsl_to_rgb_converter import hsl2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  pixel_hsl_t pixel,
    output logic       rgb_valid,
    input  logic       rgb_stall,
    output pixel_rgb_t rgb
);

    logic      front_ready;
    logic      ramp_valid;
    logic      ramp_ready;
    ramp_op_t  ramp_data;
    logic      scale_valid;
    logic      scale_ready;
    scale_op_t scale_data;

    hsl2rgb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (front_ready),
        .in_data   (pixel),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_data  (ramp_data)
    );

    hsl2rgb_ramp u_ramp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_data   (ramp_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    hsl2rgb_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (rgb_valid),
        .out_ready (!rgb_stall),
        .out_data  (rgb)
    );

    assign pixel_stall = !front_ready;

    `HSL2RGB_ASSERT(a_drain_open, !rgb_valid |-> !pixel_stall, "input stalled with an empty output register")
    `HSL2RGB_ASSERT_NEXT(a_reset_clear, !rgb_valid && !scale_valid && !ramp_valid, !rgb_valid, "output beat without a beat behind it")

endmodule

@@ design/hsl2rgb_front.sv @@
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"

module hsl2rgb_front import hsl2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pixel_hsl_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output ramp_op_t   out_data
);

    logic     a_valid_reg;
    logic     b_valid_reg;
    front_a_t a_reg;
    front_a_t a_next;
    ramp_op_t b_reg;
    ramp_op_t b_next;
    logic     a_ready;
    logic     b_ready;

    logic [C_W-1:0]     mul_a;
    logic [H_W-1:0]     mul_b;
    logic [L2_W-1:0]    prod_wide;
    logic [V_W-1:0]     v2;
    logic [L2_W-1:0]    l2_scaled;
    logic [H_W-1:0]     ang_red;
    logic [H_W-1:0]     ang_blue;
    logic [H_W:0]       sum_red;
    logic [H_W:0]       sum_blue;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage A: hue reduce, v2 partial product
    always_comb
    begin
        a_next.lower_half = (in_data.lightness <= C_W'(LIGHT_HALF));
        a_next.lightness  = in_data.lightness;
        if (in_data.hue_deg >= H_W'(HUE_WRAP))
            a_next.hue = in_data.hue_deg - H_W'(HUE_WRAP);
        else
            a_next.hue = in_data.hue_deg;
        if (a_next.lower_half)
        begin
            mul_a = in_data.lightness;
            mul_b = H_W'(FULL) + H_W'(in_data.saturation);
        end
        else
        begin
            mul_a = C_W'(FULL) - in_data.lightness;
            mul_b = H_W'(FULL) - H_W'(in_data.saturation);
        end
        prod_wide   = L2_W'(mul_a) * L2_W'(mul_b);
        a_next.prod = prod_wide[V_W-1:0];
    end

    // stage B: v1, v2 - v1, ramp weights per channel
    always_comb
    begin
        if (a_reg.lower_half)
            v2 = a_reg.prod;
        else
            v2 = V_W'(L2_W'(VV_FULL) - L2_W'(a_reg.prod));
        l2_scaled = L2_W'(a_reg.lightness) * L2_W'(TWO_FULL);
        b_next.v1   = V_W'(l2_scaled - L2_W'(v2));
        b_next.span = v2 - b_next.v1;

        sum_red  = (H_W + 1)'(a_reg.hue) + (H_W + 1)'(HUE_THIRD);
        sum_blue = (H_W + 1)'(a_reg.hue) + (H_W + 1)'(HUE_TWO_THIRD);
        if (sum_red >= (H_W + 1)'(HUE_WRAP))
            ang_red = H_W'(sum_red - (H_W + 1)'(HUE_WRAP));
        else
            ang_red = sum_red[H_W-1:0];
        if (sum_blue >= (H_W + 1)'(HUE_WRAP))
            ang_blue = H_W'(sum_blue - (H_W + 1)'(HUE_WRAP));
        else
            ang_blue = sum_blue[H_W-1:0];

        b_next.frac[CH_RED]   = ramp_frac(ang_red);
        b_next.frac[CH_GREEN] = ramp_frac(a_reg.hue);
        b_next.frac[CH_BLUE]  = ramp_frac(ang_blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
            a_reg <= a_next;
        if (b_ready && a_valid_reg)
            b_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    `HSL2RGB_ASSERT(a_v_order, b_valid_reg |-> ((L2_W'(b_reg.v1) + L2_W'(b_reg.span)) <= L2_W'(VV_FULL)), "v1/v2 out of order or above full scale")

endmodule

@@ design/hsl2rgb_ramp.sv @@
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"

module hsl2rgb_ramp import hsl2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ramp_op_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output scale_op_t out_data
);

    logic      c_valid_reg;
    logic      d_valid_reg;
    ramp_mid_t c_reg;
    ramp_mid_t c_next;
    scale_op_t d_reg;
    scale_op_t d_next;
    logic      c_ready;
    logic      d_ready;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    // stage C: v1 * 60 base, one span multiply per channel
    always_comb
    begin
        c_next.base = N_W'(in_data.v1) * N_W'(RAMP_SPAN);
        for (int k = 0; k < CH_N; k++)
            c_next.rise[k] = N_W'(in_data.span) * N_W'(in_data.frac[k]);
    end

    // stage D: ramp value plus rounding bias
    always_comb
    begin
        for (int k = 0; k < CH_N; k++)
            d_next.num[k] = c_reg.base + c_reg.rise[k] + N_W'(ROUND_BIAS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
                c_valid_reg <= in_valid;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
            c_reg <= c_next;
        if (d_ready && c_valid_reg)
            d_reg <= d_next;
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_reg;

    `HSL2RGB_ASSERT(a_num_range, d_valid_reg |-> (d_reg.num[CH_RED] <= N_W'(X_MAX) && d_reg.num[CH_GREEN] <= N_W'(X_MAX) && d_reg.num[CH_BLUE] <= N_W'(X_MAX)), "ramp value above full scale")

endmodule

@@ design/hsl2rgb_scale.sv @@
`timescale 1ns / 1ps

module hsl2rgb_scale import hsl2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  scale_op_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_rgb_t out_data
);

    logic                    valid_reg;
    pixel_rgb_t              rgb_reg;
    pixel_rgb_t              rgb_next;
    logic [CH_N-1:0][C_W-1:0] chan;
    logic [P_W-1:0]          prod [CH_N];
    logic [Q_W-1:0]          quot [CH_N];

    assign in_ready = !valid_reg || out_ready;

    // divide by 255*60 through the reciprocal, saturate to a byte
    always_comb
    begin
        for (int k = 0; k < CH_N; k++)
        begin
            prod[k] = P_W'(in_data.num[k]) * P_W'(RECIP_K);
            quot[k] = prod[k][RECIP_SHIFT +: Q_W];
            if (quot[k] > Q_W'(FULL))
                chan[k] = C_W'(FULL);
            else
                chan[k] = quot[k][C_W-1:0];
        end
        rgb_next.red   = chan[CH_RED];
        rgb_next.green = chan[CH_GREEN];
        rgb_next.blue  = chan[CH_BLUE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            rgb_reg <= rgb_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

endmodule

@@ tb/sv/tb_hsl_to_rgb_converter.sv @@
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;
    import hsl2rgb_pkg::*;

    localparam int unsigned HUE_MOD    = 360;
    localparam int unsigned BYTE_FULL  = 255;
    localparam int unsigned V_FULL     = 65025;
    localparam int unsigned LIGHT_LOW  = 127;
    localparam int unsigned SPAN       = 60;
    localparam int unsigned ROUND_ADD  = 15300;
    localparam int unsigned ROUND_DIV  = 30600;
    localparam int          DRAIN_WAIT = 10;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_LONG     = 3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       pixel_valid = 1'b0;
    logic       pixel_stall;
    pixel_hsl_t pixel = '0;
    logic       rgb_valid;
    logic       rgb_stall = 1'b0;
    pixel_rgb_t rgb;

    pixel_rgb_t rgb_expected[$];
    int         mismatches = 0;
    int         burst_left = 0;
    bit         gaps_enabled = 1'b1;
    bit         stall_enabled = 1'b1;
    int         stall_cycle = 0;
    int         stall_mode = STALL_NONE;
    int         stall_run = 0;

    hsl_to_rgb_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .rgb         (rgb)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    // ramp level at angle t, scaled by 65025*60; v1 <= v2
    function automatic int unsigned ramp_level(input int unsigned v1, input int unsigned v2,
                                               input int unsigned t);
        int unsigned level;
        if (t < 60)
            level = v1 * SPAN + (v2 - v1) * t;
        else if (t < 180)
            level = v2 * SPAN;
        else if (t < 240)
            level = v1 * SPAN + (v2 - v1) * (240 - t);
        else
            level = v1 * SPAN;
        return level;
    endfunction

    function automatic logic [7:0] round_to_byte(input int unsigned level);
        int unsigned q;
        q = (2 * level + ROUND_ADD) / ROUND_DIV;
        if (q > BYTE_FULL)
            q = BYTE_FULL;
        return q[7:0];
    endfunction

    function automatic pixel_rgb_t hsl_to_rgb_expected(input pixel_hsl_t p);
        int unsigned hue;
        int unsigned sat;
        int unsigned light;
        int unsigned v1;
        int unsigned v2;
        pixel_rgb_t  c;
        hue   = p.hue_deg % HUE_MOD;
        sat   = p.saturation;
        light = p.lightness;
        if (light <= LIGHT_LOW)
            v2 = light * (BYTE_FULL + sat);
        else
            v2 = V_FULL - (BYTE_FULL - light) * (BYTE_FULL - sat);
        v1 = 2 * BYTE_FULL * light - v2;
        c.red   = round_to_byte(ramp_level(v1, v2, (hue + 120) % HUE_MOD));
        c.green = round_to_byte(ramp_level(v1, v2, hue));
        c.blue  = round_to_byte(ramp_level(v1, v2, (hue + 240) % HUE_MOD));
        return c;
    endfunction

    function automatic void enqueue_expected(input pixel_rgb_t c);
        rgb_expected = {rgb_expected, c};
    endfunction

    // receiver backpressure, pattern picked at random: none, random, periodic or long runs
    always @(posedge clk)
    begin
        stall_cycle = stall_cycle + 1;
        if (stall_cycle % 256 == 0)
            stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
        if (!stall_enabled)
            rgb_stall <= 1'b0;
        else if (stall_mode == STALL_RANDOM)
            rgb_stall <= ($urandom_range(0, 3) == 0);
        else if (stall_mode == STALL_PERIODIC)
            rgb_stall <= (stall_cycle % 7 < 3);
        else if (stall_mode == STALL_LONG)
        begin
            if (stall_run == 0 && $urandom_range(0, 19) == 0)
                stall_run = $urandom_range(1, 12);
            rgb_stall <= (stall_run != 0);
            if (stall_run != 0)
                stall_run = stall_run - 1;
        end
        else
            rgb_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : rgb_check
        pixel_rgb_t want;
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (rgb_expected.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected rgb beat r=%0d g=%0d b=%0d",
                                 $realtime, rgb.red, rgb.green, rgb.blue);
                    mismatches++;
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    if (rgb.red !== want.red || rgb.green !== want.green
                        || rgb.blue !== want.blue)
                    begin
                        if (mismatches < 10)
                            $display("%0t: rgb mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     rgb.red, rgb.green, rgb.blue);
                        mismatches++;
                    end
                end
            end
            if (pixel_valid && !pixel_stall)
                enqueue_expected(hsl_to_rgb_expected(pixel));
        end
    end

    task automatic send_pixel(input logic [8:0] hue, input logic [7:0] sat,
                              input logic [7:0] light);
        int         gap;
        pixel_hsl_t p;
        p.hue_deg    = hue;
        p.saturation = sat;
        p.lightness  = light;
        if (gaps_enabled && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        pixel_valid <= 1'b1;
        pixel       <= p;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (rgb_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_pixels(input int count);
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] light;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                hue = 9'($urandom_range(360, 511));
            else
                hue = 9'($urandom_range(0, 359));
            pick = $urandom_range(0, 9);
            sat = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            light = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                    (pick == 2) ? 8'($urandom_range(126, 129)) : 8'($urandom_range(0, 255));
            send_pixel(hue, sat, light);
        end
    endtask

    task automatic test_corners();
        gaps_enabled  = 1'b1;
        stall_enabled = 1'b1;
        // ramp breaks at full saturation, mid lightness
        send_pixel(9'd0,   8'd255, 8'd128);
        send_pixel(9'd59,  8'd255, 8'd128);
        send_pixel(9'd60,  8'd255, 8'd128);
        send_pixel(9'd119, 8'd255, 8'd128);
        send_pixel(9'd120, 8'd255, 8'd128);
        send_pixel(9'd179, 8'd255, 8'd128);
        send_pixel(9'd180, 8'd255, 8'd128);
        send_pixel(9'd239, 8'd255, 8'd128);
        send_pixel(9'd240, 8'd255, 8'd128);
        send_pixel(9'd359, 8'd255, 8'd128);
        // hue beyond 359 wraps
        send_pixel(9'd360, 8'd255, 8'd128);
        send_pixel(9'd511, 8'd200, 8'd100);
        // gray: all channels follow lightness
        send_pixel(9'd0,   8'd0,   8'd0);
        send_pixel(9'd200, 8'd0,   8'd255);
        send_pixel(9'd45,  8'd0,   8'd127);
        send_pixel(9'd300, 8'd0,   8'd128);
        send_pixel(9'd511, 8'd0,   8'd77);
        // black, white, lightness half split
        send_pixel(9'd30,  8'd255, 8'd0);
        send_pixel(9'd30,  8'd255, 8'd255);
        send_pixel(9'd90,  8'd128, 8'd127);
        send_pixel(9'd90,  8'd128, 8'd128);
        send_pixel(9'd210, 8'd1,   8'd127);
        send_pixel(9'd210, 8'd254, 8'd128);
        send_pixel(9'd150, 8'd170, 8'd85);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        gaps_enabled  = 1'b1;
        stall_enabled = 1'b1;
        random_pixels(700);
        wait_drained();
    endtask

    task automatic test_full_rate();
        gaps_enabled  = 1'b0;
        stall_enabled = 1'b0;
        random_pixels(200);
        wait_drained();
    endtask

    task automatic test_backpressure();
        gaps_enabled  = 1'b0;
        stall_enabled = 1'b1;
        random_pixels(200);
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random_traffic();
        test_full_rate();
        test_backpressure();
        if (mismatches == 0 && rgb_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
